// ===== src/first_fit_block_allocator_assert.svh =====
// Assertion macros used by the checker file of the first-fit block allocator.
// Holds nothing but macro definitions; no other file is required.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons holds at that edge.
`define FFBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ffba assertion failed");

// Next-cycle implication: whenever ante holds, cons holds at the next edge.
`define FFBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ffba assertion failed");

`endif

// ===== src/ffba_pkg.sv =====
// Shared types and constants of the first-fit block allocator.
// Used by the controller, the datapath, the top level and the checker.
package ffba_pkg;

	// Field widths of one request and one result.
	localparam int REQ_BYTES_W    = 25;
	localparam int FREE_HEAP_W    = 2;
	localparam int FREE_BLOCK_W   = 8;
	localparam int FREE_BLOCKS_W  = 9;
	localparam int HEAP_INDEX_W   = 2;
	localparam int BLOCK_OFFSET_W = 8;
	localparam int BLOCK_COUNT_W  = 9;

	// Packing of the request tdata, lowest field first.
	localparam int IN_HEAP_LSB   = REQ_BYTES_W;
	localparam int IN_BLOCK_LSB  = IN_HEAP_LSB + FREE_HEAP_W;
	localparam int IN_BLOCKS_LSB = IN_BLOCK_LSB + FREE_BLOCK_W;
	localparam int S_TDATA_W     = 48;

	// Packing of the result tdata.
	localparam int M_FIELDS_W = HEAP_INDEX_W + BLOCK_OFFSET_W + BLOCK_COUNT_W;
	localparam int M_TDATA_W  = 24;
	localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

	// The map is kept as rows of eight block bits.
	localparam int LANES  = 8;
	localparam int LANE_W = 3;

	localparam logic OP_ALLOC    = 1'b0;
	localparam logic OP_FREE     = 1'b1;
	localparam logic ST_OK       = 1'b0;
	localparam logic ST_NO_SPACE = 1'b1;

	typedef struct packed {
		logic load;
		logic decode_free;
		logic div_step;
		logic scan_init;
		logic scan_rd;
		logic scan_eval;
		logic upd_rd;
		logic upd_wr;
		logic out_load;
	} ffba_cmd_t;

	typedef struct packed {
		logic is_free;
		logic free_ok;
		logic req_zero;
		logic too_big;
		logic found;
		logic scan_last;
		logic upd_last;
		logic out_free;
	} ffba_sts_t;

endpackage

// ===== src/ffba_ctrl.sv =====
// Sequencer of the first-fit block allocator: decode, size, scan, mark, reply.
// Depends on ffba_pkg for the command and status structs.
module ffba_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  ffba_pkg::ffba_sts_t   sts,
	output ffba_pkg::ffba_cmd_t   cmd
);

	typedef enum logic [3:0] {
		IDLE,
		DECODE,
		DIV,
		CHECK,
		SCAN_RD,
		SCAN_EV,
		UPD_RD,
		UPD_WR,
		DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   ready_q;

	assign s_tready = ready_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			IDLE: begin
				if (s_tvalid && ready_q) begin
					cmd.load = 1'b1;
					state_d  = DECODE;
				end
			end
			DECODE: begin
				priority if (sts.is_free) begin
					if (sts.free_ok) begin
						cmd.decode_free = 1'b1;
						state_d         = UPD_RD;
					end else begin
						state_d = DONE;
					end
				end else if (sts.req_zero) begin
					state_d = DONE;
				end else begin
					state_d = DIV;
				end
			end
			DIV: begin
				cmd.div_step = 1'b1;
				state_d      = CHECK;
			end
			CHECK: begin
				if (sts.too_big) begin
					state_d = DONE;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = SCAN_RD;
				end
			end
			SCAN_RD: begin
				cmd.scan_rd = 1'b1;
				state_d     = SCAN_EV;
			end
			SCAN_EV: begin
				cmd.scan_eval = 1'b1;
				priority if (sts.found) begin
					state_d = UPD_RD;
				end else if (sts.scan_last) begin
					state_d = DONE;
				end else begin
					state_d = SCAN_RD;
				end
			end
			UPD_RD: begin
				cmd.upd_rd = 1'b1;
				state_d    = UPD_WR;
			end
			UPD_WR: begin
				cmd.upd_wr = 1'b1;
				if (sts.upd_last) begin
					state_d = DONE;
				end else begin
					state_d = UPD_RD;
				end
			end
			DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = IDLE;
				end
			end
			default: begin
				state_d = IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			ready_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ready_q <= (state_d == IDLE);
		end
	end

endmodule

// ===== src/ffba_dp.sv =====
// Datapath of the first-fit block allocator: request registers, size scaling,
// block map memory, row scan and run marking logic, result register.
// Depends on ffba_pkg; driven by commands from ffba_ctrl.
module ffba_dp #(
	parameter int BLOCK_BYTES     = 65536,
	parameter int BLOCKS_PER_HEAP = 256,
	parameter int NUM_HEAPS       = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [ffba_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic                             s_tuser,
	input  ffba_pkg::ffba_cmd_t              cmd,
	output ffba_pkg::ffba_sts_t              sts,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ffba_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic                             m_tuser
);

	localparam int LANES         = ffba_pkg::LANES;
	localparam int LANE_W        = ffba_pkg::LANE_W;
	localparam int REQ_W         = ffba_pkg::REQ_BYTES_W;
	localparam int FHEAP_W       = ffba_pkg::FREE_HEAP_W;
	localparam int FBLK_W        = ffba_pkg::FREE_BLOCK_W;
	localparam int FCNT_W        = ffba_pkg::FREE_BLOCKS_W;
	localparam int OHEAP_W       = ffba_pkg::HEAP_INDEX_W;
	localparam int OOFF_W        = ffba_pkg::BLOCK_OFFSET_W;
	localparam int OCNT_W        = ffba_pkg::BLOCK_COUNT_W;
	localparam int ROWS_PER_HEAP = (BLOCKS_PER_HEAP + LANES - 1) / LANES;
	localparam int DEPTH         = NUM_HEAPS * ROWS_PER_HEAP;
	localparam int ADDR_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ROW_W         = (ROWS_PER_HEAP > 1) ? $clog2(ROWS_PER_HEAP) : 1;
	localparam int HEAP_W        = (NUM_HEAPS > 1) ? $clog2(NUM_HEAPS) : 1;
	localparam int BLK_W         = $clog2(BLOCKS_PER_HEAP);
	localparam int CNT_W         = $clog2(BLOCKS_PER_HEAP + 1);
	localparam int RB_W          = ROW_W + LANE_W;
	localparam int REQ_MAX       = (1 << REQ_W) - 1;
	localparam int NUM_W         = $clog2(REQ_MAX + BLOCK_BYTES);
	localparam int MUL_SH        = NUM_W + $clog2(BLOCK_BYTES);
	localparam int RCP_W         = NUM_W + 1;
	localparam int PROD_W        = NUM_W + RCP_W;
	localparam int FSUM_W        = FCNT_W + 1;

	// Scaled reciprocal, rounded up: exact quotients for every numerator below 2**NUM_W.
	localparam longint RECIP = ((longint'(1) << MUL_SH) + longint'(BLOCK_BYTES)
		- longint'(1)) / longint'(BLOCK_BYTES);

	localparam logic [BLK_W-1:0]  BLK_LAST  = BLK_W'(BLOCKS_PER_HEAP - 1);
	localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS_PER_HEAP - 1);
	localparam logic [HEAP_W-1:0] HEAP_LAST = HEAP_W'(NUM_HEAPS - 1);
	localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(ROWS_PER_HEAP);
	localparam logic [RCP_W-1:0]  RECIP_C   = RCP_W'(RECIP);
	localparam logic [NUM_W-1:0]  ROUND_ADD = NUM_W'(BLOCK_BYTES - 1);
	localparam logic [NUM_W-1:0]  QUO_LIM   = NUM_W'(BLOCKS_PER_HEAP);

	// Request fields.
	logic [REQ_W-1:0]   in_bytes;
	logic [FHEAP_W-1:0] in_heap;
	logic [FBLK_W-1:0]  in_first;
	logic [FCNT_W-1:0]  in_count;

	assign in_bytes = s_tdata[REQ_W-1:0];
	assign in_heap  = s_tdata[ffba_pkg::IN_HEAP_LSB +: FHEAP_W];
	assign in_first = s_tdata[ffba_pkg::IN_BLOCK_LSB +: FBLK_W];
	assign in_count = s_tdata[ffba_pkg::IN_BLOCKS_LSB +: FCNT_W];

	logic               op_q;
	logic               req_zero_q;
	logic [FHEAP_W-1:0] heap_q;
	logic [FBLK_W-1:0]  first_q;
	logic [FCNT_W-1:0]  count_q;

	// Size in blocks: the rounded-up byte count times the scaled reciprocal of the block size.
	logic [NUM_W-1:0]  num_q;
	logic [PROD_W-1:0] quo_prod;

	assign quo_prod = PROD_W'(num_q) * PROD_W'(RECIP_C);

	// Scan and update registers.
	logic [CNT_W-1:0]  need_q;
	logic [HEAP_W-1:0] scan_heap_q;
	logic [ROW_W-1:0]  scan_row_q;
	logic [ADDR_W-1:0] scan_base_q;
	logic [CNT_W-1:0]  run_q;
	logic [ADDR_W-1:0] upd_base_q;
	logic [ROW_W-1:0]  upd_row_q;
	logic [BLK_W-1:0]  upd_lo_q;
	logic [BLK_W-1:0]  upd_hi_q;
	logic              upd_set_q;

	// Result held until the reply stage is free.
	logic              res_status_q;
	logic [HEAP_W-1:0] res_heap_q;
	logic [BLK_W-1:0]  res_off_q;
	logic [CNT_W-1:0]  res_cnt_q;

	logic                     m_tvalid_q;
	logic [ffba_pkg::M_TDATA_W-1:0] m_tdata_q;
	logic                     m_tuser_q;

	// Block map memory; rows never written read as all free.
	logic [LANES-1:0]  mem [DEPTH];
	logic [DEPTH-1:0]  row_vld_q;
	logic [LANES-1:0]  rd_word_q;
	logic              rd_vld_q;
	logic [LANES-1:0]  rd_row;
	logic [LANES-1:0]  wr_word;
	logic [ADDR_W-1:0] scan_addr;
	logic [ADDR_W-1:0] upd_addr;
	logic [ADDR_W-1:0] rd_addr;

	assign scan_addr = scan_base_q + ADDR_W'(scan_row_q);
	assign upd_addr  = upd_base_q + ADDR_W'(upd_row_q);
	assign rd_addr   = cmd.scan_rd ? scan_addr : upd_addr;
	assign rd_row    = rd_vld_q ? rd_word_q : '0;

	// Free request decode.
	logic              free_ok;
	logic [FSUM_W-1:0] free_sum;
	logic [BLK_W-1:0]  free_lo;
	logic [BLK_W-1:0]  free_hi;
	logic [ADDR_W-1:0] free_base;

	assign free_ok   = (32'(heap_q) < NUM_HEAPS) && (32'(first_q) < BLOCKS_PER_HEAP)
		&& (count_q != '0);
	assign free_sum  = FSUM_W'(first_q) + FSUM_W'(count_q);
	assign free_lo   = BLK_W'(first_q);
	assign free_hi   = (32'(free_sum) > BLOCKS_PER_HEAP) ? BLK_LAST
		: BLK_W'(free_sum - FSUM_W'(1));
	assign free_base = ADDR_W'(32'(heap_q) * ROWS_PER_HEAP);

	// Row evaluation: run count over the eight blocks of the row just read.
	logic [CNT_W-1:0] run_v;
	logic             hit;
	logic [RB_W-1:0]  hit_blk;
	logic [BLK_W-1:0] hit_end;
	logic [BLK_W-1:0] alloc_lo;

	always_comb begin
		logic [RB_W-1:0] blk;
		run_v   = run_q;
		hit     = 1'b0;
		hit_blk = '0;
		for (int i = 0; i < LANES; i++) begin
			blk = {scan_row_q, LANE_W'(i)};
			if ((32'(blk) < BLOCKS_PER_HEAP) && !hit) begin
				if (rd_row[i]) begin
					run_v = '0;
				end else begin
					run_v = run_v + CNT_W'(1);
					if (run_v == need_q) begin
						hit     = 1'b1;
						hit_blk = blk;
					end
				end
			end
		end
	end

	assign hit_end  = BLK_W'(hit_blk);
	assign alloc_lo = BLK_W'(CNT_W'(hit_end) + CNT_W'(1) - need_q);

	// Row rewrite: set or clear the lanes inside the run, keep the rest.
	always_comb begin
		logic [RB_W-1:0] blk;
		for (int i = 0; i < LANES; i++) begin
			blk = {upd_row_q, LANE_W'(i)};
			if ((blk >= RB_W'(upd_lo_q)) && (blk <= RB_W'(upd_hi_q))) begin
				wr_word[i] = upd_set_q;
			end else begin
				wr_word[i] = rd_row[i];
			end
		end
	end

	assign sts.is_free   = (op_q == ffba_pkg::OP_FREE);
	assign sts.free_ok   = free_ok;
	assign sts.req_zero  = req_zero_q;
	assign sts.too_big   = (num_q > QUO_LIM);
	assign sts.found     = hit;
	assign sts.scan_last = (scan_heap_q == HEAP_LAST) && (scan_row_q == ROW_LAST);
	assign sts.upd_last  = (upd_row_q == ROW_W'(upd_hi_q >> LANE_W));
	assign sts.out_free  = !m_tvalid_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.upd_wr) begin
			mem[upd_addr] <= wr_word;
		end
		if (cmd.scan_rd || cmd.upd_rd) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q  <= '0;
			rd_vld_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.scan_rd || cmd.upd_rd) begin
				rd_vld_q <= row_vld_q[rd_addr];
			end
			if (cmd.upd_wr) begin
				row_vld_q[upd_addr] <= 1'b1;
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q         <= s_tuser;
			req_zero_q   <= (in_bytes == '0);
			heap_q       <= in_heap;
			first_q      <= in_first;
			count_q      <= in_count;
			num_q        <= NUM_W'(in_bytes) + ROUND_ADD;
			res_status_q <= (s_tuser == ffba_pkg::OP_FREE) ? ffba_pkg::ST_OK
				: ffba_pkg::ST_NO_SPACE;
			res_heap_q   <= '0;
			res_off_q    <= '0;
			res_cnt_q    <= '0;
		end
		if (cmd.div_step) begin
			num_q <= NUM_W'(quo_prod >> MUL_SH);
		end
		if (cmd.scan_init) begin
			need_q      <= CNT_W'(num_q);
			scan_heap_q <= '0;
			scan_row_q  <= '0;
			scan_base_q <= '0;
			run_q       <= '0;
		end
		if (cmd.scan_eval) begin
			priority if (hit) begin
				res_status_q <= ffba_pkg::ST_OK;
				res_heap_q   <= scan_heap_q;
				res_off_q    <= alloc_lo;
				res_cnt_q    <= need_q;
				upd_base_q   <= scan_base_q;
				upd_row_q    <= ROW_W'(alloc_lo >> LANE_W);
				upd_lo_q     <= alloc_lo;
				upd_hi_q     <= hit_end;
				upd_set_q    <= 1'b1;
			end else if (scan_row_q == ROW_LAST) begin
				scan_heap_q <= scan_heap_q + HEAP_W'(1);
				scan_row_q  <= '0;
				scan_base_q <= scan_base_q + ROW_STEP;
				run_q       <= '0;
			end else begin
				scan_row_q <= scan_row_q + ROW_W'(1);
				run_q      <= run_v;
			end
		end
		if (cmd.decode_free) begin
			upd_base_q <= free_base;
			upd_row_q  <= ROW_W'(free_lo >> LANE_W);
			upd_lo_q   <= free_lo;
			upd_hi_q   <= free_hi;
			upd_set_q  <= 1'b0;
		end
		if (cmd.upd_wr) begin
			upd_row_q <= upd_row_q + ROW_W'(1);
		end
		if (cmd.out_load) begin
			m_tuser_q <= res_status_q;
			m_tdata_q <= {{ffba_pkg::M_PAD_W{1'b0}}, OCNT_W'(res_cnt_q),
				OOFF_W'(res_off_q), OHEAP_W'(res_heap_q)};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== src/first_fit_block_allocator.sv =====
// Work per request: a free reads and rewrites each map row its run touches (8 blocks a row);
// an allocate sizes the request, scans map rows until a fit, then reads and rewrites each row
// it marks; with the default parameters at most 128 rows are scanned and 32 marked.
// One request is in work at a time, so the next request is taken only after the result of the
// last is loaded; the row scan reads the map one row at a time from one port.
// Reset is asynchronous, active low; row valid bits mark the whole map free at once.
//
// Top level of the first-fit block allocator. Depends on ffba_pkg, ffba_ctrl and ffba_dp.
module first_fit_block_allocator #(
	parameter int BLOCK_BYTES     = 65536,
	parameter int BLOCKS_PER_HEAP = 256,
	parameter int NUM_HEAPS       = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Request channel.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// request_bytes[24:0], free_heap[26:25], free_block[34:27], free_blocks[43:35], zero pad
	input  logic [ffba_pkg::S_TDATA_W-1:0] s_tdata,
	// op[0]: 0 allocate, 1 free
	input  logic                           s_tuser,
	// Result channel.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// heap_index[1:0], block_offset[9:2], block_count[18:10], zero pad
	output logic [ffba_pkg::M_TDATA_W-1:0] m_tdata,
	// status[0]: 0 success, 1 no space found
	output logic                           m_tuser
);

	// The controller walks each request through its steps. An allocate first rounds the
	// byte size up to whole blocks with one multiplication by a scaled reciprocal of the
	// block size, then scans the map row by row for the first free run of that length,
	// heap by heap, restarting the run count at every used block and at every heap
	// boundary. A found run is then marked used with a read-modify-write over the rows it
	// covers. A free clears its run the same way, cut at the end of its heap. Every
	// request yields exactly one result transfer.
	//
	// The result sits in an output register, so a new request is taken while the
	// previous result still waits for m_tready; only the final load of the next result
	// waits for that register to drain.

	ffba_pkg::ffba_cmd_t cmd;
	ffba_pkg::ffba_sts_t sts;

	ffba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ffba_dp #(
		.BLOCK_BYTES     (BLOCK_BYTES),
		.BLOCKS_PER_HEAP (BLOCKS_PER_HEAP),
		.NUM_HEAPS       (NUM_HEAPS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== src/ffba_chk.sv =====
// Port-level checker of the first-fit block allocator, bound to the top level.
// Depends on ffba_pkg and the assertion macros header.
`include "first_fit_block_allocator_assert.svh"

module ffba_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [ffba_pkg::S_TDATA_W-1:0] s_tdata,
	input logic                           s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [ffba_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                           m_tuser
);

	// Only one request is in work: an accepted transfer closes the request side.
	`FFBA_ASSERT_NXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// A failed allocation reports no heap, offset or count.
	`FFBA_ASSERT_IMP(a_fail_fields_zero, clk, arst_n, m_tvalid && (m_tuser == ffba_pkg::ST_NO_SPACE), m_tdata == '0)

	// A new result appears only at the end of a request's work.
	`FFBA_ASSERT_IMP(a_result_after_work, clk, arst_n, $rose(m_tvalid), $past(!s_tready))

	// A stalled result holds.
	`FFBA_ASSERT_NXT(a_hold_stalled, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// The request payload is watched only through the bind; it adds no rule of its own.
	logic unused_in;
	assign unused_in = ^{s_tdata, s_tuser};

endmodule

bind first_fit_block_allocator ffba_chk u_ffba_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== dv/first_fit_block_allocator_test.sv =====
// Self-checking testbench of the first-fit block allocator: directed and random requests,
// predicted by a bitmap scoreboard. Depends on ffba_pkg and first_fit_block_allocator.
module first_fit_block_allocator_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BLOCK_BYTES     = 65536;
	localparam int BLOCKS_PER_HEAP = 256;
	localparam int NUM_HEAPS       = 4;
	localparam int REQ_W           = ffba_pkg::REQ_BYTES_W;
	localparam int FHEAP_W         = ffba_pkg::FREE_HEAP_W;
	localparam int FBLK_W          = ffba_pkg::FREE_BLOCK_W;
	localparam int FCNT_W          = ffba_pkg::FREE_BLOCKS_W;
	// This limit allows many times the run of the slowest request.
	localparam int CYCLE_LIMIT     = 4000000;
	localparam int DRAIN_CYCLES    = 400;
	localparam int HOLD_CYCLES     = 2000;
	localparam int PHASE_ITEMS     = 475;

	typedef struct packed {
		logic                                status;
		logic [ffba_pkg::HEAP_INDEX_W-1:0]   heap;
		logic [ffba_pkg::BLOCK_OFFSET_W-1:0] offset;
		logic [ffba_pkg::BLOCK_COUNT_W-1:0]  count;
	} alloc_result_t;

	// Holds a copy of the used-block map and the results still owed by the block.
	class block_map_scoreboard;
		bit            used_map[NUM_HEAPS][BLOCKS_PER_HEAP];
		alloc_result_t expected_results[$];
		int            errors;

		function new();
			errors = 0;
			foreach (used_map[h, b]) used_map[h][b] = 1'b0;
		endfunction

		function void report_mismatch(string what);
			$display("mismatch: %s", what);
			errors++;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// Applies one accepted request to the map and queues the result it must produce.
		function alloc_result_t note_request(logic op, logic [ffba_pkg::S_TDATA_W-1:0] data);
			alloc_result_t            res;
			logic [REQ_W:0]           rounded;
			int                       need;
			int                       run;
			int                       heap;
			int                       first;
			int                       stop;
			bit                       placed;
			res    = '0;
			placed = 1'b0;
			if (op == ffba_pkg::OP_ALLOC) begin
				res.status = ffba_pkg::ST_NO_SPACE;
				rounded    = {1'b0, data[REQ_W-1:0]} + (REQ_W + 1)'(BLOCK_BYTES - 1);
				need       = int'(rounded / BLOCK_BYTES);
				// A zero-size request rounds to no blocks and never fits.
				if (need != 0 && need <= BLOCKS_PER_HEAP) begin
					for (int h = 0; h < NUM_HEAPS && !placed; h++) begin
						run = 0;
						for (int j = 0; j < BLOCKS_PER_HEAP && !placed; j++) begin
							// A used block restarts the count of free blocks.
							if (used_map[h][j]) begin
								run = 0;
							end else begin
								run++;
								if (run == need) begin
									for (int k = j + 1 - need; k <= j; k++) used_map[h][k] = 1'b1;
									res.status = ffba_pkg::ST_OK;
									res.heap   = h[ffba_pkg::HEAP_INDEX_W-1:0];
									res.offset = ffba_pkg::BLOCK_OFFSET_W'(j + 1 - need);
									res.count  = ffba_pkg::BLOCK_COUNT_W'(need);
									placed     = 1'b1;
								end
							end
						end
					end
				end
			end else begin
				// A free always succeeds; a run past the end of its heap is cut there, and a
				// heap or start out of range leaves the map alone.
				res.status = ffba_pkg::ST_OK;
				heap  = int'(data[ffba_pkg::IN_HEAP_LSB +: FHEAP_W]);
				first = int'(data[ffba_pkg::IN_BLOCK_LSB +: FBLK_W]);
				stop  = first + int'(data[ffba_pkg::IN_BLOCKS_LSB +: FCNT_W]);
				if (stop > BLOCKS_PER_HEAP) stop = BLOCKS_PER_HEAP;
				if (heap < NUM_HEAPS && first < BLOCKS_PER_HEAP)
					for (int k = first; k < stop; k++) used_map[heap][k] = 1'b0;
			end
			expected_results.push_back(res);
			return res;
		endfunction

		function void check_result(logic status, logic [ffba_pkg::M_TDATA_W-1:0] tdata);
			alloc_result_t want;
			alloc_result_t got;
			got.status = status;
			got.heap   = tdata[0 +: ffba_pkg::HEAP_INDEX_W];
			got.offset = tdata[ffba_pkg::HEAP_INDEX_W +: ffba_pkg::BLOCK_OFFSET_W];
			got.count  = tdata[ffba_pkg::HEAP_INDEX_W + ffba_pkg::BLOCK_OFFSET_W +:
				ffba_pkg::BLOCK_COUNT_W];
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result %p with no request waiting", got));
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status)
					report_mismatch($sformatf("status %b, wanted %b", got.status, want.status));
				if (got.heap !== want.heap)
					report_mismatch($sformatf("heap %0d, wanted %0d", got.heap, want.heap));
				if (got.offset !== want.offset)
					report_mismatch($sformatf("offset %0d, wanted %0d", got.offset, want.offset));
				if (got.count !== want.count)
					report_mismatch($sformatf("count %0d, wanted %0d", got.count, want.count));
			end
		endfunction
	endclass

	logic                           clk      = 1'b0;
	logic                           arst_n   = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [ffba_pkg::S_TDATA_W-1:0] s_tdata  = '0;
	logic                           s_tuser  = ffba_pkg::OP_ALLOC;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [ffba_pkg::M_TDATA_W-1:0] m_tdata;
	logic                           m_tuser;

	block_map_scoreboard  map_board = new();
	alloc_result_t        live_runs[$];
	int                   sender_idle_pct = 0;
	int                   receiver_stall_pct = 0;
	bit                   hold_request = 1'b0;
	int                   hold_left = 0;

	first_fit_block_allocator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [ffba_pkg::S_TDATA_W-1:0] pack_request(logic [REQ_W-1:0] bytes,
			logic [FHEAP_W-1:0] heap, logic [FBLK_W-1:0] blk, logic [FCNT_W-1:0] cnt);
		logic [ffba_pkg::S_TDATA_W-1:0] data;
		data = '0;
		data[0 +: REQ_W]                          = bytes;
		data[ffba_pkg::IN_HEAP_LSB +: FHEAP_W]    = heap;
		data[ffba_pkg::IN_BLOCK_LSB +: FBLK_W]    = blk;
		data[ffba_pkg::IN_BLOCKS_LSB +: FCNT_W]   = cnt;
		return data;
	endfunction

	// Offers one request until it is taken, then idles for a random gap.
	task automatic send_request(logic op, logic [ffba_pkg::S_TDATA_W-1:0] data);
		alloc_result_t res;
		int            gap;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
		res = map_board.note_request(op, data);
		if (op == ffba_pkg::OP_ALLOC && res.status == ffba_pkg::ST_OK) live_runs.push_back(res);
		gap = 0;
		while ($urandom_range(0, 99) < sender_idle_pct) gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_alloc(logic [REQ_W-1:0] bytes);
		send_request(ffba_pkg::OP_ALLOC, pack_request(bytes, FHEAP_W'($urandom),
			FBLK_W'($urandom), FCNT_W'($urandom)));
	endtask

	task automatic send_free(logic [FHEAP_W-1:0] heap, logic [FBLK_W-1:0] blk,
			logic [FCNT_W-1:0] cnt);
		send_request(ffba_pkg::OP_FREE, pack_request(REQ_W'($urandom), heap, blk, cnt));
	endtask

	task automatic pause_until_drained(int extra);
		s_tvalid <= 1'b0;
		while (map_board.pending() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// Mostly small allocations and frees of live runs, so the map stays fragmented.
	task automatic random_request();
		int            pick;
		int            need;
		int            idx;
		alloc_result_t run;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			pick = $urandom_range(0, 99);
			if (pick < 60)      need = $urandom_range(1, 8);
			else if (pick < 90) need = $urandom_range(9, 64);
			else if (pick < 97) need = $urandom_range(65, BLOCKS_PER_HEAP);
			else                need = 0;
			if (need == 0)
				send_alloc(REQ_W'($urandom));
			else
				send_alloc(REQ_W'((need - 1) * BLOCK_BYTES + $urandom_range(1, BLOCK_BYTES)));
		end else if (pick < 85 && live_runs.size() != 0) begin
			idx = $urandom_range(0, live_runs.size() - 1);
			run = live_runs[idx];
			live_runs.delete(idx);
			send_free(run.heap, run.offset, run.count);
		end else if (pick < 96) begin
			send_free(FHEAP_W'($urandom), FBLK_W'($urandom), FCNT_W'($urandom));
		end else begin
			// Clears a whole heap, with the count exact or running past the end.
			send_free(FHEAP_W'($urandom), '0, $urandom_range(0, 1) ? 9'd256 : 9'd511);
		end
	endtask

	// The receiver takes or stalls results; a hold-off request blocks it for a long stretch.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) map_board.check_result(m_tuser, m_tdata);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
				m_tready     <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("first_fit_block_allocator regression: fail");
		$finish;
	end

	initial begin
		int sender_pcts[4];
		int receiver_pcts[4];
		sender_pcts   = '{0, 71, 0, 22};
		receiver_pcts = '{0, 0, 71, 22};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: size edges, run restart, runs ending at a heap's last block,
		// frees cut at the heap end, frees of free blocks, and a full map.
		send_alloc(0);
		send_alloc(1);
		send_alloc(REQ_W'(BLOCK_BYTES));
		send_alloc(REQ_W'(BLOCK_BYTES + 1));
		send_alloc('1);
		send_alloc(REQ_W'(BLOCKS_PER_HEAP * BLOCK_BYTES + 1));
		send_alloc(REQ_W'(BLOCKS_PER_HEAP * BLOCK_BYTES));
		send_free(0, 1, 1);
		send_alloc(REQ_W'(2 * BLOCK_BYTES));
		send_alloc(1);
		send_free(1, 0, 0);
		send_free(1, 250, '1);
		send_alloc(REQ_W'(250 * BLOCK_BYTES));
		send_alloc(REQ_W'(6 * BLOCK_BYTES));
		send_free(2, 0, 9'd256);
		send_alloc(REQ_W'(BLOCKS_PER_HEAP * BLOCK_BYTES));
		send_alloc(REQ_W'(BLOCKS_PER_HEAP * BLOCK_BYTES));
		send_alloc(1);
		send_free(3, 255, '1);
		send_alloc(1);
		for (int h = 0; h < NUM_HEAPS; h++) send_free(FHEAP_W'(h), '0, '1);
		pause_until_drained(0);
		live_runs.delete();

		for (int p = 0; p < 4; p++) begin
			sender_idle_pct    = sender_pcts[p];
			receiver_stall_pct = receiver_pcts[p];
			// In the first phase the receiver holds off while requests keep coming.
			if (p == 0) hold_request = 1'b1;
			repeat (PHASE_ITEMS) random_request();
			pause_until_drained(p == 3 ? DRAIN_CYCLES : 0);
		end

		if (map_board.pending() != 0)
			map_board.report_mismatch($sformatf("%0d results never came", map_board.pending()));
		if (map_board.errors == 0)
			$display("first_fit_block_allocator regression: pass");
		else
			$display("first_fit_block_allocator regression: fail");
		$finish;
	end

endmodule
